### hw/rtl/scl_pkg.sv
// ----------------------------------------------------------------------------
// scl_pkg: shared types, codes and lexing functions
// Mode encoding, token record, lexer state and the per-character step that the
// front end chains and the end-of-stream close.
// ----------------------------------------------------------------------------
package scl_pkg;

    localparam int POS_W      = 20;
    localparam int LINE_W     = 16;
    localparam int WORD_BUF   = 7;
    localparam int WL_W       = $clog2(WORD_BUF + 2);
    localparam int WI_W       = $clog2(WORD_BUF);
    localparam int MAX_TOK    = 3;
    localparam int CNT_W      = $clog2(MAX_TOK + 1);
    localparam int FIFO_DEPTH = 4;
    localparam int FP_W       = $clog2(FIFO_DEPTH);
    localparam int NUM_KW     = 45;
    localparam int STEPS      = 4;

    typedef logic [6:0]        kind_t;
    typedef logic [2:0]        err_t;
    typedef logic [POS_W-1:0]  pos_t;
    typedef logic [LINE_W-1:0] line_t;

    localparam line_t LINE_MAX = '1;

    localparam err_t E_NONE    = 3'd0;
    localparam err_t E_COMMENT = 3'd1;
    localparam err_t E_BIN     = 3'd2;
    localparam err_t E_HEX     = 3'd3;
    localparam err_t E_BANG    = 3'd4;
    localparam err_t E_STRING  = 3'd5;
    localparam err_t E_UNKNOWN = 3'd6;

    localparam kind_t K_NAME    = 7'd0;
    localparam kind_t K_BIN     = 7'd46;
    localparam kind_t K_HEX     = 7'd47;
    localparam kind_t K_DEC     = 7'd48;
    localparam kind_t K_FLOAT   = 7'd49;
    localparam kind_t K_LPAREN  = 7'd51;
    localparam kind_t K_RPAREN  = 7'd52;
    localparam kind_t K_LBRACK  = 7'd53;
    localparam kind_t K_RBRACK  = 7'd54;
    localparam kind_t K_LBRACE  = 7'd55;
    localparam kind_t K_RBRACE  = 7'd56;
    localparam kind_t K_COMMA   = 7'd57;
    localparam kind_t K_DOT     = 7'd58;
    localparam kind_t K_COLON   = 7'd59;
    localparam kind_t K_SEMI    = 7'd60;
    localparam kind_t K_AMP     = 7'd61;
    localparam kind_t K_AT      = 7'd62;
    localparam kind_t K_PERCENT = 7'd63;
    localparam kind_t K_DQSTR   = 7'd64;
    localparam kind_t K_SQSTR   = 7'd65;
    localparam kind_t K_EQEQ    = 7'd66;
    localparam kind_t K_ASSIGN  = 7'd67;
    localparam kind_t K_LE      = 7'd68;
    localparam kind_t K_SWAP    = 7'd69;
    localparam kind_t K_LT      = 7'd70;
    localparam kind_t K_GE      = 7'd71;
    localparam kind_t K_GT      = 7'd72;
    localparam kind_t K_PLUSEQ  = 7'd73;
    localparam kind_t K_PLUS    = 7'd74;
    localparam kind_t K_MINUSEQ = 7'd75;
    localparam kind_t K_ARROW   = 7'd76;
    localparam kind_t K_MINUS   = 7'd77;
    localparam kind_t K_STAREQ  = 7'd78;
    localparam kind_t K_STAR    = 7'd79;
    localparam kind_t K_SLASHEQ = 7'd80;
    localparam kind_t K_SLASH   = 7'd81;
    localparam kind_t K_NE      = 7'd82;
    localparam kind_t K_EOF     = 7'd83;

    typedef enum logic [4:0] {
        M_IDLE, M_SLASH, M_BLOCK, M_BLOCK_STAR, M_LINE, M_ZERO, M_BIN0, M_BIN,
        M_HEX0, M_HEX, M_DEC, M_FRAC, M_WORD, M_DQ, M_SQ, M_EQ, M_LT, M_LTDASH,
        M_GT, M_PLUS, M_MINUS, M_STAR, M_BANG
    } mode_t;

    // keyword text is right-justified: last character in the low byte
    localparam logic [NUM_KW-1:0][55:0] KW_TEXT = {
        56'("xor"),  56'("while"), 56'("use"),   56'("type"),   56'("true"),
        56'("struct"), 56'("stack!"), 56'("self"), 56'("return"), 56'("or"),
        56'("null"), 56'("not"),   56'("none"),  56'("macro"),  56'("in"),
        56'("if"),   56'("heap!"), 56'("globals"), 56'("for"),  56'("false"),
        56'("else"), 56'("elif"),  56'("cast!"), 56'("and"),    56'("char"),
        56'("float"), 56'("f128"), 56'("f64"),   56'("f32"),    56'("f16"),
        56'("f8"),   56'("uint"),  56'("u128"),  56'("u64"),    56'("u32"),
        56'("u16"),  56'("u8"),    56'("int"),   56'("i128"),   56'("i64"),
        56'("i32"),  56'("i16"),   56'("i8"),    56'("bool"),   56'("fn")
    };

    localparam logic [NUM_KW-1:0][3:0] KW_LEN = {
        4'd3, 4'd5, 4'd3, 4'd4, 4'd4, 4'd6, 4'd6, 4'd4, 4'd6, 4'd2,
        4'd4, 4'd3, 4'd4, 4'd5, 4'd2, 4'd2, 4'd5, 4'd7, 4'd3, 4'd5,
        4'd4, 4'd4, 4'd5, 4'd3, 4'd4, 4'd5, 4'd4, 4'd3, 4'd3, 4'd3,
        4'd2, 4'd4, 4'd4, 4'd3, 4'd3, 4'd3, 4'd2, 4'd3, 4'd4, 4'd3,
        4'd3, 4'd3, 4'd2, 4'd4, 4'd2
    };

    typedef struct packed {
        mode_t                      mode;
        logic [WORD_BUF-1:0][7:0]   wchars;
        logic [WL_W-1:0]            wlen;
        logic                       bang;
        pos_t                       pos;
        line_t                      line;
        line_t                      col;
        pos_t                       tstart;
        line_t                      tline;
        line_t                      tcol;
        logic                       halted;
    } lex_state_t;

    localparam lex_state_t LEX_RESET = '{
        mode: M_IDLE, wchars: '0, wlen: '0, bang: 1'b0, pos: '0,
        line: line_t'(1), col: line_t'(1), tstart: '0,
        tline: line_t'(1), tcol: line_t'(1), halted: 1'b0
    };

    typedef struct packed {
        kind_t  kind;
        pos_t   start_pos;
        pos_t   end_pos;
        line_t  line_number;
        line_t  column_number;
        err_t   error_code;
        logic   last_token;
    } token_t;

    typedef struct packed {
        lex_state_t st;
        logic       emit;
        token_t     tk;
        logic       again;
    } step_t;

    typedef struct packed {
        logic [CNT_W-1:0]          count;
        token_t [MAX_TOK-1:0]      toks;
    } bundle_t;

    typedef struct packed {
        logic full;
        logic empty;
    } q_status_t;

    function automatic line_t sat_inc(line_t v);
        return (v == LINE_MAX) ? v : v + line_t'(1);
    endfunction

    function automatic logic is_digit(logic [7:0] c);
        return c inside {[8'h30:8'h39]};
    endfunction

    function automatic logic is_alpha(logic [7:0] c);
        return c inside {[8'h61:8'h7a], [8'h41:8'h5a]};
    endfunction

    function automatic logic is_word(logic [7:0] c);
        return is_alpha(c) || is_digit(c) || c == "_" || c == "!";
    endfunction

    function automatic logic is_hex(logic [7:0] c);
        return is_digit(c) || c inside {[8'h61:8'h66], [8'h41:8'h46]} || c == "_";
    endfunction

    function automatic kind_t single_kind(logic [7:0] c);
        kind_t k;
        case (c)
            "(":     k = K_LPAREN;
            ")":     k = K_RPAREN;
            "[":     k = K_LBRACK;
            "]":     k = K_RBRACK;
            "{":     k = K_LBRACE;
            "}":     k = K_RBRACE;
            ",":     k = K_COMMA;
            ".":     k = K_DOT;
            ":":     k = K_COLON;
            ";":     k = K_SEMI;
            "&":     k = K_AMP;
            "@":     k = K_AT;
            "%":     k = K_PERCENT;
            default: k = K_NAME;
        endcase
        return k;
    endfunction

    // parallel compare against every keyword; K_NAME when none matches
    function automatic kind_t kw_lookup(lex_state_t s);
        kind_t k;
        logic  hit;
        k = K_NAME;
        for (int i = 0; i < NUM_KW; i++)
        begin
            hit = (s.wlen == WL_W'(KW_LEN[i]));
            for (int j = 0; j < WORD_BUF; j++)
            begin
                if (j < int'(KW_LEN[i]) &&
                    s.wchars[j] != KW_TEXT[i][8*(int'(KW_LEN[i])-1-j) +: 8])
                begin
                    hit = 1'b0;
                end
            end
            if (hit)
            begin
                k = kind_t'(i + 1);
            end
        end
        return k;
    endfunction

    function automatic token_t mk_tok(lex_state_t s, kind_t k, pos_t e, err_t er);
        token_t t;
        t.kind          = k;
        t.start_pos     = s.tstart;
        t.end_pos       = e;
        t.line_number   = s.tline;
        t.column_number = s.tcol;
        t.error_code    = er;
        t.last_token    = 1'b0;
        return t;
    endfunction

    function automatic step_t do_tok(step_t r, kind_t k, pos_t e);
        step_t o;
        o         = r;
        o.emit    = 1'b1;
        o.tk      = mk_tok(r.st, k, e, E_NONE);
        o.st.mode = M_IDLE;
        return o;
    endfunction

    function automatic step_t do_fail(step_t r, err_t er, pos_t e);
        step_t o;
        o           = r;
        o.emit      = 1'b1;
        o.tk        = mk_tok(r.st, K_NAME, e, er);
        o.st.mode   = M_IDLE;
        o.st.halted = 1'b1;
        return o;
    endfunction

    function automatic step_t finish_word(step_t r, pos_t e);
        kind_t k;
        step_t o;
        k = kw_lookup(r.st);
        if (k != K_NAME)
            o = do_tok(r, k, e);
        else if (r.st.bang)
            o = do_fail(r, E_BANG, e);
        else
            o = do_tok(r, K_NAME, e);
        return o;
    endfunction

    // emit '<' now and leave a '-' token pending one place on
    function automatic step_t split_swap(step_t r);
        step_t o;
        o           = do_tok(r, K_LT, r.st.tstart + pos_t'(1));
        o.st.tstart = r.st.tstart + pos_t'(1);
        o.st.tcol   = sat_inc(r.st.tcol);
        o.st.mode   = M_MINUS;
        return o;
    endfunction

    function automatic step_t blank_step(lex_state_t s);
        step_t r;
        r.st    = s;
        r.emit  = 1'b0;
        r.tk    = '0;
        r.again = 1'b0;
        return r;
    endfunction

    // one pass of the lexer over character c at offset p
    function automatic step_t handle(lex_state_t s, logic [7:0] c, pos_t p);
        step_t r;
        pos_t  p1;
        r  = blank_step(s);
        p1 = p + pos_t'(1);
        case (s.mode)
            M_IDLE:
            begin
                r.st.tstart = p;
                r.st.tline  = s.line;
                r.st.tcol   = s.col;
                if (c == " " || c == "\n")
                    r.st.mode = M_IDLE;
                else if (c == "0")
                    r.st.mode = M_ZERO;
                else if (is_digit(c))
                    r.st.mode = M_DEC;
                else if (is_alpha(c) || c == "_")
                begin
                    r.st.wchars[0] = c;
                    r.st.wlen      = WL_W'(1);
                    r.st.bang      = 1'b0;
                    r.st.mode      = M_WORD;
                end
                else if (single_kind(c) != K_NAME)
                    r = do_tok(r, single_kind(c), p1);
                else
                begin
                    case (c)
                        "\"":    r.st.mode = M_DQ;
                        "'":     r.st.mode = M_SQ;
                        "=":     r.st.mode = M_EQ;
                        "<":     r.st.mode = M_LT;
                        ">":     r.st.mode = M_GT;
                        "+":     r.st.mode = M_PLUS;
                        "-":     r.st.mode = M_MINUS;
                        "*":     r.st.mode = M_STAR;
                        "/":     r.st.mode = M_SLASH;
                        "!":     r.st.mode = M_BANG;
                        default: r = do_fail(r, E_UNKNOWN, p1);
                    endcase
                end
            end
            M_SLASH:
            begin
                if (c == "*")
                    r.st.mode = M_BLOCK_STAR;
                else if (c == "/")
                    r.st.mode = M_LINE;
                else if (c == "=")
                    r = do_tok(r, K_SLASHEQ, p1);
                else
                begin
                    r       = do_tok(r, K_SLASH, p);
                    r.again = 1'b1;
                end
            end
            M_BLOCK, M_BLOCK_STAR:
            begin
                if (s.mode == M_BLOCK_STAR && c == "/")
                    r.st.mode = M_IDLE;
                else
                    r.st.mode = (c == "*") ? M_BLOCK_STAR : M_BLOCK;
            end
            M_LINE:
            begin
                if (c == "\n")
                    r.st.mode = M_IDLE;
            end
            M_ZERO:
            begin
                if (c == "b" || c == "B")
                    r.st.mode = M_BIN0;
                else if (c == "x" || c == "X")
                    r.st.mode = M_HEX0;
                else
                begin
                    r.st.mode = M_DEC;
                    r.again   = 1'b1;
                end
            end
            M_BIN0, M_BIN:
            begin
                if (c == "0" || c == "1" || c == "_")
                    r.st.mode = M_BIN;
                else if (s.mode == M_BIN0)
                    r = do_fail(r, E_BIN, p);
                else
                begin
                    r       = do_tok(r, K_BIN, p);
                    r.again = 1'b1;
                end
            end
            M_HEX0, M_HEX:
            begin
                if (is_hex(c))
                    r.st.mode = M_HEX;
                else if (s.mode == M_HEX0)
                    r = do_fail(r, E_HEX, p);
                else
                begin
                    r       = do_tok(r, K_HEX, p);
                    r.again = 1'b1;
                end
            end
            M_DEC:
            begin
                if (is_digit(c) || c == "_")
                    r.st.mode = M_DEC;
                else if (c == ".")
                    r.st.mode = M_FRAC;
                else
                begin
                    r       = do_tok(r, K_DEC, p);
                    r.again = 1'b1;
                end
            end
            M_FRAC:
            begin
                if (!(is_digit(c) || c == "_"))
                begin
                    r       = do_tok(r, K_FLOAT, p);
                    r.again = 1'b1;
                end
            end
            M_WORD:
            begin
                if (is_word(c))
                begin
                    if (s.wlen < WL_W'(WORD_BUF))
                        r.st.wchars[s.wlen[WI_W-1:0]] = c;
                    if (s.wlen <= WL_W'(WORD_BUF))
                        r.st.wlen = s.wlen + WL_W'(1);
                    if (c == "!")
                        r.st.bang = 1'b1;
                end
                else
                begin
                    r       = finish_word(r, p);
                    r.again = !r.st.halted;
                end
            end
            M_DQ:
            begin
                if (c == "\"")
                    r = do_tok(r, K_DQSTR, p1);
            end
            M_SQ:
            begin
                if (c == "'")
                    r = do_tok(r, K_SQSTR, p1);
            end
            M_EQ:
            begin
                if (c == "=")
                    r = do_tok(r, K_EQEQ, p1);
                else
                begin
                    r       = do_tok(r, K_ASSIGN, p);
                    r.again = 1'b1;
                end
            end
            M_LT:
            begin
                if (c == "=")
                    r = do_tok(r, K_LE, p1);
                else if (c == "-")
                    r.st.mode = M_LTDASH;
                else
                begin
                    r       = do_tok(r, K_LT, p);
                    r.again = 1'b1;
                end
            end
            M_LTDASH:
            begin
                if (c == ">")
                    r = do_tok(r, K_SWAP, p1);
                else
                begin
                    r       = split_swap(r);
                    r.again = 1'b1;
                end
            end
            M_GT:
            begin
                if (c == "=")
                    r = do_tok(r, K_GE, p1);
                else
                begin
                    r       = do_tok(r, K_GT, p);
                    r.again = 1'b1;
                end
            end
            M_PLUS:
            begin
                if (c == "=")
                    r = do_tok(r, K_PLUSEQ, p1);
                else
                begin
                    r       = do_tok(r, K_PLUS, p);
                    r.again = 1'b1;
                end
            end
            M_MINUS:
            begin
                if (c == "=")
                    r = do_tok(r, K_MINUSEQ, p1);
                else if (c == ">")
                    r = do_tok(r, K_ARROW, p1);
                else
                begin
                    r       = do_tok(r, K_MINUS, p);
                    r.again = 1'b1;
                end
            end
            M_STAR:
            begin
                if (c == "=")
                    r = do_tok(r, K_STAREQ, p1);
                else
                begin
                    r       = do_tok(r, K_STAR, p);
                    r.again = 1'b1;
                end
            end
            M_BANG:
            begin
                if (c == "=")
                    r = do_tok(r, K_NE, p1);
                else
                    r = do_fail(r, E_BANG, p);
            end
            default:
            begin
                r.st.mode = M_IDLE;
                r.again   = 1'b1;
            end
        endcase
        return r;
    endfunction

    // close the pending token at end of stream; again set after a '<-' split
    function automatic step_t fin_step(lex_state_t s, pos_t e);
        step_t r;
        r = blank_step(s);
        case (s.mode)
            M_ZERO, M_DEC:         r = do_tok(r, K_DEC, e);
            M_BIN:                 r = do_tok(r, K_BIN, e);
            M_HEX:                 r = do_tok(r, K_HEX, e);
            M_FRAC:                r = do_tok(r, K_FLOAT, e);
            M_BIN0:                r = do_fail(r, E_BIN, e);
            M_HEX0:                r = do_fail(r, E_HEX, e);
            M_WORD:                r = finish_word(r, e);
            M_DQ, M_SQ:            r = do_fail(r, E_STRING, e);
            M_BLOCK, M_BLOCK_STAR: r = do_fail(r, E_COMMENT, e);
            M_EQ:                  r = do_tok(r, K_ASSIGN, e);
            M_LT:                  r = do_tok(r, K_LT, e);
            M_LTDASH:
            begin
                r       = split_swap(r);
                r.again = 1'b1;
            end
            M_GT:                  r = do_tok(r, K_GT, e);
            M_PLUS:                r = do_tok(r, K_PLUS, e);
            M_MINUS:               r = do_tok(r, K_MINUS, e);
            M_STAR:                r = do_tok(r, K_STAR, e);
            M_SLASH:               r = do_tok(r, K_SLASH, e);
            M_BANG:                r = do_fail(r, E_BANG, e);
            default:               r = blank_step(s);
        endcase
        return r;
    endfunction

endpackage

### hw/rtl/scl_if.sv
// ----------------------------------------------------------------------------
// scl_if: stream channels of the lexer
// Character channel in and token channel out, valid/ready handshake.
// ----------------------------------------------------------------------------
interface scl_char_if;
    logic       valid;
    logic       ready;
    logic [7:0] char_code;
    logic       last_char;

    modport source (output valid, output char_code, output last_char, input ready);
    modport sink   (input valid, input char_code, input last_char, output ready);
endinterface

interface scl_token_if;
    logic                 valid;
    logic                 ready;
    scl_pkg::kind_t       token_kind;
    scl_pkg::pos_t        start_pos;
    scl_pkg::pos_t        end_pos;
    scl_pkg::line_t       line_number;
    scl_pkg::line_t       column_number;
    scl_pkg::err_t        error_code;
    logic                 last_token;

    modport source (output valid, output token_kind, output start_pos, output end_pos,
                    output line_number, output column_number, output error_code,
                    output last_token, input ready);
    modport sink   (input valid, input token_kind, input start_pos, input end_pos,
                    input line_number, input column_number, input error_code,
                    input last_token, output ready);
endinterface

### hw/rtl/scl_front.sv
// ----------------------------------------------------------------------------
// scl_front: character intake and lexing
// Runs the lexer over one character a cycle while the queue is not full;
// pushes the tokens it closes, as one word of up to three, into the queue.
// ----------------------------------------------------------------------------
module scl_front
(
    input  logic               clk,
    input  logic               rst_n,
    scl_char_if.sink           chars,
    input  scl_pkg::q_status_t qs,
    output logic               push,
    output scl_pkg::bundle_t   bundle
);

    scl_pkg::lex_state_t st_reg;
    scl_pkg::lex_state_t st_next;
    scl_pkg::lex_state_t st;
    scl_pkg::step_t      r;
    scl_pkg::bundle_t    b;
    logic                run;
    logic                take;

    assign chars.ready = !qs.full;
    assign take        = chars.valid && chars.ready;

    always_comb
    begin
        b   = '0;
        st  = st_reg;
        run = !st_reg.halted;
        r   = scl_pkg::blank_step(st_reg);
        for (int i = 0; i < scl_pkg::STEPS; i++)
        begin
            if (run)
            begin
                r  = scl_pkg::handle(st, chars.char_code, st.pos);
                st = r.st;
                if (r.emit && b.count < scl_pkg::CNT_W'(scl_pkg::MAX_TOK))
                begin
                    b.toks[b.count[1:0]] = r.tk;
                    b.count              = b.count + 1'b1;
                end
                run = r.again && !r.st.halted;
            end
        end

        st.pos = st.pos + scl_pkg::pos_t'(1);
        if (chars.char_code == "\n")
        begin
            st.line = scl_pkg::sat_inc(st.line);
            st.col  = scl_pkg::line_t'(1);
        end
        else
        begin
            st.col = scl_pkg::sat_inc(st.col);
        end

        if (chars.last_char)
        begin
            if (!st.halted)
            begin
                for (int i = 0; i < 2; i++)
                begin
                    if (i == 0 || r.again)
                    begin
                        r  = scl_pkg::fin_step(st, st.pos);
                        st = r.st;
                        if (r.emit && b.count < scl_pkg::CNT_W'(scl_pkg::MAX_TOK))
                        begin
                            b.toks[b.count[1:0]] = r.tk;
                            b.count              = b.count + 1'b1;
                        end
                    end
                end
            end
            if (b.count == '0)
            begin
                b.toks[0]               = '0;
                b.toks[0].kind          = scl_pkg::K_EOF;
                b.toks[0].start_pos     = st.pos;
                b.toks[0].end_pos       = st.pos;
                b.toks[0].line_number   = st.line;
                b.toks[0].column_number = st.col;
                b.toks[0].error_code    = scl_pkg::E_NONE;
                b.count                 = scl_pkg::CNT_W'(1);
            end
            b.toks[b.count[1:0] - 2'd1].last_token = 1'b1;
            st = scl_pkg::LEX_RESET;
        end

        st_next = take ? st : st_reg;
    end

    assign push   = take && (b.count != '0);
    assign bundle = b;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            st_reg <= scl_pkg::LEX_RESET;
        else
            st_reg <= st_next;
    end

endmodule

### hw/rtl/scl_queue.sv
// ----------------------------------------------------------------------------
// scl_queue: token word queue
// Short FIFO of token words between the lexer front end and the output side.
// ----------------------------------------------------------------------------
module scl_queue
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    input  scl_pkg::bundle_t    push_data,
    input  logic                pop,
    output scl_pkg::bundle_t    head,
    output scl_pkg::q_status_t  qs
);

    scl_pkg::bundle_t                  mem [scl_pkg::FIFO_DEPTH];
    logic [scl_pkg::FP_W-1:0]          wr_reg;
    logic [scl_pkg::FP_W-1:0]          rd_reg;
    logic [scl_pkg::FP_W:0]            cnt_reg;
    logic [scl_pkg::FP_W-1:0]          wr_next;
    logic [scl_pkg::FP_W-1:0]          rd_next;
    logic [scl_pkg::FP_W:0]            cnt_next;

    assign qs.full  = (cnt_reg == (scl_pkg::FP_W+1)'(scl_pkg::FIFO_DEPTH));
    assign qs.empty = (cnt_reg == '0);
    assign head     = mem[rd_reg];

    always_comb
    begin
        wr_next  = wr_reg + (push ? 1'b1 : 1'b0);
        rd_next  = rd_reg + (pop ? 1'b1 : 1'b0);
        cnt_next = cnt_reg + (push ? 1'b1 : 1'b0) - (pop ? 1'b1 : 1'b0);
    end

    always_ff @(posedge clk)
    begin
        if (push)
            mem[wr_reg] <= push_data;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg  <= '0;
            rd_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            wr_reg  <= wr_next;
            rd_reg  <= rd_next;
            cnt_reg <= cnt_next;
        end
    end

endmodule

### hw/rtl/scl_back.sv
// ----------------------------------------------------------------------------
// scl_back: token output
// Walks the head word's tokens onto the token channel, one per ready cycle.
// ----------------------------------------------------------------------------
module scl_back
(
    input  logic               clk,
    input  logic               rst_n,
    input  scl_pkg::bundle_t   head,
    input  scl_pkg::q_status_t qs,
    output logic               pop,
    scl_token_if.source        tokens
);

    logic [1:0]       idx_reg;
    logic [1:0]       idx_next;
    scl_pkg::token_t  tk;
    logic             fire;
    logic             at_end;

    assign tk     = head.toks[idx_reg];
    assign fire   = tokens.valid && tokens.ready;
    assign at_end = (idx_reg == head.count[1:0] - 2'd1);
    assign pop    = fire && at_end;

    assign tokens.valid         = !qs.empty;
    assign tokens.token_kind    = tk.kind;
    assign tokens.start_pos     = tk.start_pos;
    assign tokens.end_pos       = tk.end_pos;
    assign tokens.line_number   = tk.line_number;
    assign tokens.column_number = tk.column_number;
    assign tokens.error_code    = tk.error_code;
    assign tokens.last_token    = tk.last_token;

    always_comb
    begin
        idx_next = idx_reg;
        if (fire)
            idx_next = at_end ? 2'd0 : idx_reg + 2'd1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            idx_reg <= '0;
        else
            idx_reg <= idx_next;
    end

endmodule

### hw/rtl/source_char_lexer_core.sv
// Path: a token closed by an accepted character is written into the queue
//   and offered on the token channel from there.
// Flow: one character per cycle while the queue is not full; a four-word queue
//   absorbs characters that close two or three tokens at once.
// Reset: asynchronous, clears the lexer state and the queue; no clearing pass.
// ----------------------------------------------------------------------------
// source_char_lexer_core: streaming source lexer
// Front end lexes characters, queue decouples, back end serialises tokens.
// ----------------------------------------------------------------------------
module source_char_lexer_core
(
    input  logic         clk,
    input  logic         rst_n,
    scl_char_if.sink     chars,
    scl_token_if.source  tokens
);

    scl_pkg::q_status_t qs;
    scl_pkg::bundle_t   push_data;
    scl_pkg::bundle_t   head;
    logic               push;
    logic               pop;

    scl_front u_front
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .chars  (chars),
        .qs     (qs),
        .push   (push),
        .bundle (push_data)
    );

    scl_queue u_queue
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_data),
        .pop       (pop),
        .head      (head),
        .qs        (qs)
    );

    scl_back u_back
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .head   (head),
        .qs     (qs),
        .pop    (pop),
        .tokens (tokens)
    );

endmodule

### hw/rtl/scl_checker.sv
// ----------------------------------------------------------------------------
// scl_checker: port-level checks on the lexer
// Watches the token channel of the top level; attached by bind.
// ----------------------------------------------------------------------------
module scl_checker
(
    input  logic           clk,
    input  logic           rst_n,
    input  logic           out_valid,
    input  logic           out_ready,
    input  scl_pkg::kind_t kind,
    input  scl_pkg::pos_t  start_p,
    input  scl_pkg::pos_t  end_p,
    input  scl_pkg::err_t  err,
    input  logic           last
);

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(kind) && $stable(start_p))
        else $error("token dropped or changed while stalled");

    a_err_kind: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && err != scl_pkg::E_NONE |-> kind == scl_pkg::K_NAME)
        else $error("error token with non-name kind");

    a_eof: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && kind == scl_pkg::K_EOF |->
            last && start_p == end_p && err == scl_pkg::E_NONE)
        else $error("malformed end-of-input token");

    a_kind_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> kind <= scl_pkg::K_EOF && err <= scl_pkg::E_UNKNOWN)
        else $error("token kind or error out of range");

endmodule

bind source_char_lexer_core scl_checker u_scl_checker
(
    .clk       (clk),
    .rst_n     (rst_n),
    .out_valid (tokens.valid),
    .out_ready (tokens.ready),
    .kind      (tokens.token_kind),
    .start_p   (tokens.start_pos),
    .end_p     (tokens.end_pos),
    .err       (tokens.error_code),
    .last      (tokens.last_token)
);

### bench/scl_tb_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// scl_tb_if: bench-side view of the lexer channels
// Nothing of its own: the bench instantiates the channel interfaces from the
// RTL; this file only carries the shared word record used by the bench.
// ----------------------------------------------------------------------------
package scl_tb_pkg;

    typedef struct {
        logic [7:0] code;
        logic       last;
    } char_word_t;

endpackage

### bench/source_char_lexer_core_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// source_char_lexer_core_tb: self-checking bench for the streaming lexer
// Feeds directed and random source text with random gaps on both channels,
// predicts every token from a behavioural lexer and compares field by field.
// ----------------------------------------------------------------------------
module source_char_lexer_core_tb;

    localparam int LIMIT_CYCLES = 400000;
    localparam scl_pkg::kind_t KW_UINT = 7'd14;

    typedef struct {
        scl_pkg::kind_t kind;
        scl_pkg::pos_t  spos;
        scl_pkg::pos_t  epos;
        scl_pkg::line_t line;
        scl_pkg::line_t col;
        scl_pkg::err_t  err;
        logic           last;
    } tok_rec_t;

    typedef struct {
        string          text;
        logic           check_first;
        scl_pkg::kind_t kind;
        scl_pkg::err_t  err;
    } script_row_t;

    logic clk;
    logic rst_n;
    scl_char_if  chars ();
    scl_token_if tokens ();

    source_char_lexer_core dut (.clk(clk), .rst_n(rst_n), .chars(chars), .tokens(tokens));

    // lexer prediction state
    scl_pkg::mode_t lx_mode;
    logic [7:0]     lx_word [scl_pkg::WORD_BUF];
    int             lx_wlen;
    logic           lx_bang;
    scl_pkg::pos_t  lx_pos;
    scl_pkg::line_t lx_line, lx_col, lx_tline, lx_tcol;
    scl_pkg::pos_t  lx_tstart;
    logic           lx_halted;

    tok_rec_t                token_queue [$];
    tok_rec_t                step_out [$];
    scl_tb_pkg::char_word_t  char_stream [$];
    script_row_t             rows [$];
    int                      stream_idx;
    bit                      stream_fresh;
    int                      fail_count;
    int                      cycle_count;
    int                      stall_left;
    logic                    send_done;

    string kw_names [45] = '{
        "fn", "bool", "i8", "i16", "i32", "i64", "i128", "int",
        "u8", "u16", "u32", "u64", "u128", "uint",
        "f8", "f16", "f32", "f64", "f128", "float",
        "char", "and", "cast!", "elif", "else", "false", "for", "globals",
        "heap!", "if", "in", "macro", "none", "not", "null", "or", "return",
        "self", "stack!", "struct", "true", "type", "use", "while", "xor"};

    initial
    begin
        clk = 1'b0;
    end

    always #5 clk = ~clk;

    function automatic scl_pkg::line_t bump(scl_pkg::line_t v);
        return (v == scl_pkg::LINE_MAX) ? v : v + scl_pkg::line_t'(1);
    endfunction

    function automatic bit dig(logic [7:0] c);
        return c >= "0" && c <= "9";
    endfunction

    function automatic bit alpha(logic [7:0] c);
        return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
    endfunction

    function automatic bit hexch(logic [7:0] c);
        return dig(c) || (c >= "a" && c <= "f") || (c >= "A" && c <= "F") || c == "_";
    endfunction

    function automatic int sym_kind(logic [7:0] c);
        case (c)
            "(": return scl_pkg::K_LPAREN;
            ")": return scl_pkg::K_RPAREN;
            "[": return scl_pkg::K_LBRACK;
            "]": return scl_pkg::K_RBRACK;
            "{": return scl_pkg::K_LBRACE;
            "}": return scl_pkg::K_RBRACE;
            ",": return scl_pkg::K_COMMA;
            ".": return scl_pkg::K_DOT;
            ":": return scl_pkg::K_COLON;
            ";": return scl_pkg::K_SEMI;
            "&": return scl_pkg::K_AMP;
            "@": return scl_pkg::K_AT;
            "%": return scl_pkg::K_PERCENT;
            default: return -1;
        endcase
    endfunction

    function automatic void lex_clear();
        lx_mode = scl_pkg::M_IDLE;
        lx_wlen = 0;
        lx_bang = 1'b0;
        lx_pos = '0;
        lx_line = 1;
        lx_col = 1;
        lx_tstart = '0;
        lx_tline = 1;
        lx_tcol = 1;
        lx_halted = 1'b0;
    endfunction

    function automatic void push_tok(scl_pkg::kind_t k, scl_pkg::pos_t e, scl_pkg::err_t er);
        tok_rec_t t;
        t.kind = k;
        t.spos = lx_tstart;
        t.epos = e;
        t.line = lx_tline;
        t.col = lx_tcol;
        t.err = er;
        t.last = 1'b0;
        if (step_out.size() < scl_pkg::MAX_TOK)
            step_out.push_back(t);
        lx_mode = scl_pkg::M_IDLE;
        if (er != scl_pkg::E_NONE)
            lx_halted = 1'b1;
    endfunction

    function automatic void close_word(scl_pkg::pos_t e);
        string w;
        int    hit;
        hit = -1;
        if (lx_wlen <= scl_pkg::WORD_BUF)
        begin
            w = "";
            for (int i = 0; i < lx_wlen; i++)
                w = {w, string'(lx_word[i])};
            for (int k = 0; k < 45; k++)
                if (kw_names[k] == w)
                    hit = k;
        end
        if (hit >= 0)
            push_tok(scl_pkg::kind_t'(hit + 1), e, scl_pkg::E_NONE);
        else if (lx_bang)
            push_tok(scl_pkg::K_NAME, e, scl_pkg::E_BANG);
        else
            push_tok(scl_pkg::K_NAME, e, scl_pkg::E_NONE);
    endfunction

    function automatic void split_lt();
        push_tok(scl_pkg::K_LT, lx_tstart + scl_pkg::pos_t'(1), scl_pkg::E_NONE);
        lx_tstart = lx_tstart + scl_pkg::pos_t'(1);
        lx_tcol = bump(lx_tcol);
        lx_mode = scl_pkg::M_MINUS;
    endfunction

    // one pass over c; returns 1 to look at c again in the new mode
    function automatic bit lex_pass(logic [7:0] c, scl_pkg::pos_t p);
        scl_pkg::pos_t p1;
        int            sk;
        p1 = p + scl_pkg::pos_t'(1);
        case (lx_mode)
            scl_pkg::M_IDLE:
            begin
                lx_tstart = p;
                lx_tline = lx_line;
                lx_tcol = lx_col;
                sk = sym_kind(c);
                if (c == " " || c == "\n") ;
                else if (c == "0") lx_mode = scl_pkg::M_ZERO;
                else if (dig(c)) lx_mode = scl_pkg::M_DEC;
                else if (alpha(c) || c == "_")
                begin
                    lx_word[0] = c;
                    lx_wlen = 1;
                    lx_bang = 1'b0;
                    lx_mode = scl_pkg::M_WORD;
                end
                else if (sk >= 0) push_tok(scl_pkg::kind_t'(sk), p1, scl_pkg::E_NONE);
                else
                    case (c)
                        "\"": lx_mode = scl_pkg::M_DQ;
                        "'": lx_mode = scl_pkg::M_SQ;
                        "=": lx_mode = scl_pkg::M_EQ;
                        "<": lx_mode = scl_pkg::M_LT;
                        ">": lx_mode = scl_pkg::M_GT;
                        "+": lx_mode = scl_pkg::M_PLUS;
                        "-": lx_mode = scl_pkg::M_MINUS;
                        "*": lx_mode = scl_pkg::M_STAR;
                        "/": lx_mode = scl_pkg::M_SLASH;
                        "!": lx_mode = scl_pkg::M_BANG;
                        default: push_tok(scl_pkg::K_NAME, p1, scl_pkg::E_UNKNOWN);
                    endcase
                return 0;
            end
            scl_pkg::M_SLASH:
            begin
                if (c == "*") lx_mode = scl_pkg::M_BLOCK_STAR;
                else if (c == "/") lx_mode = scl_pkg::M_LINE;
                else if (c == "=") push_tok(scl_pkg::K_SLASHEQ, p1, scl_pkg::E_NONE);
                else
                begin
                    push_tok(scl_pkg::K_SLASH, p, scl_pkg::E_NONE);
                    return 1;
                end
                return 0;
            end
            scl_pkg::M_BLOCK, scl_pkg::M_BLOCK_STAR:
            begin
                if (lx_mode == scl_pkg::M_BLOCK_STAR && c == "/") lx_mode = scl_pkg::M_IDLE;
                else lx_mode = (c == "*") ? scl_pkg::M_BLOCK_STAR : scl_pkg::M_BLOCK;
                return 0;
            end
            scl_pkg::M_LINE:
            begin
                if (c == "\n") lx_mode = scl_pkg::M_IDLE;
                return 0;
            end
            scl_pkg::M_ZERO:
            begin
                if (c == "b" || c == "B") lx_mode = scl_pkg::M_BIN0;
                else if (c == "x" || c == "X") lx_mode = scl_pkg::M_HEX0;
                else
                begin
                    lx_mode = scl_pkg::M_DEC;
                    return 1;
                end
                return 0;
            end
            scl_pkg::M_BIN0, scl_pkg::M_BIN:
            begin
                if (c == "0" || c == "1" || c == "_") lx_mode = scl_pkg::M_BIN;
                else if (lx_mode == scl_pkg::M_BIN0) push_tok(scl_pkg::K_NAME, p, scl_pkg::E_BIN);
                else
                begin
                    push_tok(scl_pkg::K_BIN, p, scl_pkg::E_NONE);
                    return 1;
                end
                return 0;
            end
            scl_pkg::M_HEX0, scl_pkg::M_HEX:
            begin
                if (hexch(c)) lx_mode = scl_pkg::M_HEX;
                else if (lx_mode == scl_pkg::M_HEX0) push_tok(scl_pkg::K_NAME, p, scl_pkg::E_HEX);
                else
                begin
                    push_tok(scl_pkg::K_HEX, p, scl_pkg::E_NONE);
                    return 1;
                end
                return 0;
            end
            scl_pkg::M_DEC:
            begin
                if (dig(c) || c == "_") return 0;
                if (c == ".")
                begin
                    lx_mode = scl_pkg::M_FRAC;
                    return 0;
                end
                push_tok(scl_pkg::K_DEC, p, scl_pkg::E_NONE);
                return 1;
            end
            scl_pkg::M_FRAC:
            begin
                if (dig(c) || c == "_") return 0;
                push_tok(scl_pkg::K_FLOAT, p, scl_pkg::E_NONE);
                return 1;
            end
            scl_pkg::M_WORD:
            begin
                if (alpha(c) || dig(c) || c == "_" || c == "!")
                begin
                    if (lx_wlen < scl_pkg::WORD_BUF) lx_word[lx_wlen] = c;
                    if (lx_wlen <= scl_pkg::WORD_BUF) lx_wlen++;
                    if (c == "!") lx_bang = 1'b1;
                    return 0;
                end
                close_word(p);
                return !lx_halted;
            end
            scl_pkg::M_DQ:
            begin
                if (c == "\"") push_tok(scl_pkg::K_DQSTR, p1, scl_pkg::E_NONE);
                return 0;
            end
            scl_pkg::M_SQ:
            begin
                if (c == "'") push_tok(scl_pkg::K_SQSTR, p1, scl_pkg::E_NONE);
                return 0;
            end
            scl_pkg::M_EQ:
            begin
                if (c == "=")
                begin
                    push_tok(scl_pkg::K_EQEQ, p1, scl_pkg::E_NONE);
                    return 0;
                end
                push_tok(scl_pkg::K_ASSIGN, p, scl_pkg::E_NONE);
                return 1;
            end
            scl_pkg::M_LT:
            begin
                if (c == "=")
                begin
                    push_tok(scl_pkg::K_LE, p1, scl_pkg::E_NONE);
                    return 0;
                end
                if (c == "-")
                begin
                    lx_mode = scl_pkg::M_LTDASH;
                    return 0;
                end
                push_tok(scl_pkg::K_LT, p, scl_pkg::E_NONE);
                return 1;
            end
            scl_pkg::M_LTDASH:
            begin
                if (c == ">")
                begin
                    push_tok(scl_pkg::K_SWAP, p1, scl_pkg::E_NONE);
                    return 0;
                end
                split_lt();
                return 1;
            end
            scl_pkg::M_GT:
            begin
                if (c == "=")
                begin
                    push_tok(scl_pkg::K_GE, p1, scl_pkg::E_NONE);
                    return 0;
                end
                push_tok(scl_pkg::K_GT, p, scl_pkg::E_NONE);
                return 1;
            end
            scl_pkg::M_PLUS:
            begin
                if (c == "=")
                begin
                    push_tok(scl_pkg::K_PLUSEQ, p1, scl_pkg::E_NONE);
                    return 0;
                end
                push_tok(scl_pkg::K_PLUS, p, scl_pkg::E_NONE);
                return 1;
            end
            scl_pkg::M_MINUS:
            begin
                if (c == "=")
                begin
                    push_tok(scl_pkg::K_MINUSEQ, p1, scl_pkg::E_NONE);
                    return 0;
                end
                if (c == ">")
                begin
                    push_tok(scl_pkg::K_ARROW, p1, scl_pkg::E_NONE);
                    return 0;
                end
                push_tok(scl_pkg::K_MINUS, p, scl_pkg::E_NONE);
                return 1;
            end
            scl_pkg::M_STAR:
            begin
                if (c == "=")
                begin
                    push_tok(scl_pkg::K_STAREQ, p1, scl_pkg::E_NONE);
                    return 0;
                end
                push_tok(scl_pkg::K_STAR, p, scl_pkg::E_NONE);
                return 1;
            end
            scl_pkg::M_BANG:
            begin
                if (c == "=") push_tok(scl_pkg::K_NE, p1, scl_pkg::E_NONE);
                else push_tok(scl_pkg::K_NAME, p, scl_pkg::E_BANG);
                return 0;
            end
            default:
            begin
                lx_mode = scl_pkg::M_IDLE;
                return 1;
            end
        endcase
    endfunction

    function automatic void close_stream(scl_pkg::pos_t e);
        case (lx_mode)
            scl_pkg::M_ZERO, scl_pkg::M_DEC: push_tok(scl_pkg::K_DEC, e, scl_pkg::E_NONE);
            scl_pkg::M_BIN: push_tok(scl_pkg::K_BIN, e, scl_pkg::E_NONE);
            scl_pkg::M_HEX: push_tok(scl_pkg::K_HEX, e, scl_pkg::E_NONE);
            scl_pkg::M_FRAC: push_tok(scl_pkg::K_FLOAT, e, scl_pkg::E_NONE);
            scl_pkg::M_BIN0: push_tok(scl_pkg::K_NAME, e, scl_pkg::E_BIN);
            scl_pkg::M_HEX0: push_tok(scl_pkg::K_NAME, e, scl_pkg::E_HEX);
            scl_pkg::M_WORD: close_word(e);
            scl_pkg::M_DQ, scl_pkg::M_SQ: push_tok(scl_pkg::K_NAME, e, scl_pkg::E_STRING);
            scl_pkg::M_BLOCK, scl_pkg::M_BLOCK_STAR:
                push_tok(scl_pkg::K_NAME, e, scl_pkg::E_COMMENT);
            scl_pkg::M_EQ: push_tok(scl_pkg::K_ASSIGN, e, scl_pkg::E_NONE);
            scl_pkg::M_LT: push_tok(scl_pkg::K_LT, e, scl_pkg::E_NONE);
            scl_pkg::M_LTDASH:
            begin
                split_lt();
                push_tok(scl_pkg::K_MINUS, e, scl_pkg::E_NONE);
            end
            scl_pkg::M_GT: push_tok(scl_pkg::K_GT, e, scl_pkg::E_NONE);
            scl_pkg::M_PLUS: push_tok(scl_pkg::K_PLUS, e, scl_pkg::E_NONE);
            scl_pkg::M_MINUS: push_tok(scl_pkg::K_MINUS, e, scl_pkg::E_NONE);
            scl_pkg::M_STAR: push_tok(scl_pkg::K_STAR, e, scl_pkg::E_NONE);
            scl_pkg::M_SLASH: push_tok(scl_pkg::K_SLASH, e, scl_pkg::E_NONE);
            scl_pkg::M_BANG: push_tok(scl_pkg::K_NAME, e, scl_pkg::E_BANG);
            default: ;
        endcase
    endfunction

    // advance the predictor by one accepted word, queue the tokens it closes
    task automatic lex_char(logic [7:0] c, logic last);
        tok_rec_t t;
        step_out.delete();
        if (!lx_halted)
            for (int i = 0; i < scl_pkg::STEPS; i++)
                if (!lex_pass(c, lx_pos) || lx_halted)
                    break;
        lx_pos = lx_pos + scl_pkg::pos_t'(1);
        if (c == "\n")
        begin
            lx_line = bump(lx_line);
            lx_col = 1;
        end
        else
            lx_col = bump(lx_col);
        if (last)
        begin
            if (!lx_halted)
                close_stream(lx_pos);
            if (step_out.size() == 0)
            begin
                t.kind = scl_pkg::K_EOF;
                t.spos = lx_pos;
                t.epos = lx_pos;
                t.line = lx_line;
                t.col = lx_col;
                t.err = scl_pkg::E_NONE;
                t.last = 1'b0;
                step_out.push_back(t);
            end
            step_out[step_out.size() - 1].last = 1'b1;
            lex_clear();
        end
        foreach (step_out[i])
        begin
            t = step_out[i];
            // directed rows with check_first pin kind and error of their first token
            if (stream_fresh && stream_idx < rows.size() && rows[stream_idx].check_first)
            begin
                t.kind = rows[stream_idx].kind;
                t.err = rows[stream_idx].err;
            end
            stream_fresh = 1'b0;
            token_queue.push_back(t);
        end
        if (last)
        begin
            stream_idx++;
            stream_fresh = 1'b1;
        end
    endtask

    task automatic add_text(string s, bit last);
        scl_tb_pkg::char_word_t w;
        for (int i = 0; i < s.len(); i++)
        begin
            w.code = s[i];
            w.last = last && (i == s.len() - 1);
            char_stream.push_back(w);
        end
    endtask

    function automatic string rand_piece();
        string pieces [24] = '{
            "x1_ab", "0b1_0", "0xFf_", "123", "4.5", "7.", "\"s t\"", "'q'",
            "<->", "<-3", "<=", ">=", "->", "-=", "+=", "*=", "/=", "!=",
            "// c\n", "/* a*b */", "(", ";", "\n", "name!"};
        string s;
        int    r;
        r = $urandom_range(0, 9);
        if (r < 4)
            return kw_names[$urandom_range(0, 44)];
        if (r < 9)
            return pieces[$urandom_range(0, 23)];
        s = " ";
        s[0] = $urandom_range(1, 255);
        return s;
    endfunction

    // sender: walk the character stream with random gaps
    initial
    begin : sender
        string sep;
        int    gap;
        rows = '{
            '{"x", 1, scl_pkg::K_NAME, scl_pkg::E_NONE},
            '{" ", 1, scl_pkg::K_EOF, scl_pkg::E_NONE},
            '{"/* open", 1, scl_pkg::K_NAME, scl_pkg::E_COMMENT},
            '{"0b", 1, scl_pkg::K_NAME, scl_pkg::E_BIN},
            '{"0x;", 1, scl_pkg::K_NAME, scl_pkg::E_HEX},
            '{"oops! ", 1, scl_pkg::K_NAME, scl_pkg::E_BANG},
            '{"! ", 1, scl_pkg::K_NAME, scl_pkg::E_BANG},
            '{"\"abc", 1, scl_pkg::K_NAME, scl_pkg::E_STRING},
            '{"\t", 1, scl_pkg::K_NAME, scl_pkg::E_UNKNOWN},
            '{"\xff", 1, scl_pkg::K_NAME, scl_pkg::E_UNKNOWN},
            '{"uint f128 cast! heap! stack! globals", 1, KW_UINT, scl_pkg::E_NONE},
            '{"/*/ 1. 0b1 0xa 9", 0, scl_pkg::K_NAME, scl_pkg::E_NONE},
            '{"<-1 <-", 0, scl_pkg::K_NAME, scl_pkg::E_NONE},
            '{"abcdefghij xor// tail", 0, scl_pkg::K_NAME, scl_pkg::E_NONE},
            '{"a\n b\n\n  c 'x' == = < > + - * / &@%", 0, scl_pkg::K_NAME, scl_pkg::E_NONE}
        };
        chars.valid <= 1'b0;
        chars.char_code <= 8'h00;
        chars.last_char <= 1'b0;
        wait (rst_n === 1'b1);
        @(posedge clk);
        foreach (rows[i])
            add_text(rows[i].text, 1);
        for (int n = 0; n < 9; n++)
        begin
            sep = ($urandom_range(0, 3) == 0) ? "\n" : " ";
            for (int j = $urandom_range(1, 8); j > 0; j--)
                add_text({rand_piece(), sep}, 0);
            add_text(rand_piece(), 1);
        end
        for (int idx = 0; idx < char_stream.size(); idx++)
        begin
            if (idx == 60)
            begin
                // hold until every token so far has drained
                chars.valid <= 1'b0;
                wait (token_queue.size() == 0);
                @(posedge clk);
            end
            gap = ($urandom_range(0, 2) == 0) ?
                  (($urandom_range(0, 9) == 0) ? $urandom_range(5, 30) : $urandom_range(1, 3)) : 0;
            if (idx > 200 && idx < 260)
                gap = 0;
            if (gap > 0)
            begin
                chars.valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            chars.valid <= 1'b1;
            chars.char_code <= char_stream[idx].code;
            chars.last_char <= char_stream[idx].last;
            @(posedge clk);
            while (chars.ready !== 1'b1)
                @(posedge clk);
        end
        chars.valid <= 1'b0;
        send_done = 1'b1;
    end

    always @(posedge clk)
    begin
        if (rst_n && chars.valid && chars.ready)
            lex_char(chars.char_code, chars.last_char);
    end

    // receiver: mostly ready, short random stalls and now and then a long one
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tokens.ready <= 1'b0;
            stall_left <= 0;
        end
        else if (stall_left > 0)
        begin
            tokens.ready <= 1'b0;
            stall_left <= stall_left - 1;
        end
        else if ($urandom_range(0, 39) == 0)
        begin
            tokens.ready <= 1'b0;
            stall_left <= $urandom_range(5, 30);
        end
        else
            tokens.ready <= ($urandom_range(0, 3) != 0);
    end

    always @(posedge clk)
    begin : token_check
        tok_rec_t e;
        if (rst_n && tokens.valid && tokens.ready)
        begin
            if (token_queue.size() == 0)
            begin
                $error("token_kind: expected none, got %0d at %0d",
                       tokens.token_kind, tokens.start_pos);
                fail_count++;
            end
            else
            begin
                e = token_queue.pop_front();
                if (tokens.token_kind !== e.kind)
                begin
                    $error("token_kind: expected %0d, got %0d", e.kind, tokens.token_kind);
                    fail_count++;
                end
                if (tokens.start_pos !== e.spos)
                begin
                    $error("start_pos: expected %0d, got %0d", e.spos, tokens.start_pos);
                    fail_count++;
                end
                if (tokens.end_pos !== e.epos)
                begin
                    $error("end_pos: expected %0d, got %0d", e.epos, tokens.end_pos);
                    fail_count++;
                end
                if (tokens.line_number !== e.line)
                begin
                    $error("line_number: expected %0d, got %0d", e.line, tokens.line_number);
                    fail_count++;
                end
                if (tokens.column_number !== e.col)
                begin
                    $error("column_number: expected %0d, got %0d", e.col, tokens.column_number);
                    fail_count++;
                end
                if (tokens.error_code !== e.err)
                begin
                    $error("error_code: expected %0d, got %0d", e.err, tokens.error_code);
                    fail_count++;
                end
                if (tokens.last_token !== e.last)
                begin
                    $error("last_token: expected %0d, got %0d", e.last, tokens.last_token);
                    fail_count++;
                end
            end
        end
    end

    initial
    begin : control
        fail_count = 0;
        cycle_count = 0;
        send_done = 1'b0;
        stream_idx = 0;
        stream_fresh = 1'b1;
        rst_n = 1'b0;
        lex_clear();
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        while (!(send_done && token_queue.size() == 0) && cycle_count < LIMIT_CYCLES)
        begin
            @(posedge clk);
            cycle_count++;
        end
        if (cycle_count >= LIMIT_CYCLES)
        begin
            $display("status: fail");
            $finish;
        end
        else
        begin
            repeat (20) @(posedge clk);
            if (fail_count == 0)
                $display("status: pass");
            else
                $display("status: fail");
            $finish;
        end
    end

endmodule

### sim.f
hw/rtl/scl_pkg.sv
hw/rtl/scl_if.sv
hw/rtl/scl_front.sv
hw/rtl/scl_queue.sv
hw/rtl/scl_back.sv
hw/rtl/source_char_lexer_core.sv
hw/rtl/scl_checker.sv
bench/scl_tb_if.sv
bench/source_char_lexer_core_tb.sv
